@@ src/wsh_pkg.sv @@
// Shared types and constants for the window stack hit test block.
// Used by wsh_ctrl, wsh_dp and window_stack_hit_test_raise; depends on nothing.
`timescale 1ns / 1ps

package wsh_pkg;

    localparam int MAX_WINDOWS = 16;
    localparam int COORD_BITS  = 12;

    localparam int IN_COORD_W = 12;
    localparam int POS_W      = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam int CNT_W      = $clog2(MAX_WINDOWS + 1);
    localparam int ID_W       = 5;
    localparam int STATUS_W   = 2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_CLICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT     = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status_code;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_CMP,
        S_MOVE
    } t_state;

    // One entry of the stack: its rectangle and its store index.
    typedef struct packed {
        logic [COORD_BITS-1:0] x_low;
        logic [COORD_BITS-1:0] y_low;
        logic [COORD_BITS-1:0] x_high;
        logic [COORD_BITS-1:0] y_high;
        logic [POS_W-1:0]      idx;
    } t_cell;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic do_load;
        logic emit_full;
        logic do_cmp;
        logic do_move;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
    } t_dp_status;

endpackage

@@ src/wsh_ctrl.sv @@
// Controller state machine for the window stack hit test block.
// Depends on wsh_pkg; drives the command word of wsh_dp.
`timescale 1ns / 1ps

module wsh_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_req_type,
    input  wsh_pkg::t_dp_status i_status,
    output wsh_pkg::t_cmd       o_cmd,
    output logic                busy
);
    import wsh_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (i_req_type == REQ_CLICK) ? S_CMP : S_LOAD;
                end
            end
            S_LOAD:  n_state = S_IDLE;
            S_CMP:   n_state = S_MOVE;
            S_MOVE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = start;
            end
            S_LOAD: begin
                o_cmd.do_load   = !i_status.full;
                o_cmd.emit_full = i_status.full;
            end
            S_CMP: begin
                o_cmd.do_cmp = 1'b1;
            end
            S_MOVE: begin
                o_cmd.do_move = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ src/wsh_dp.sv @@
// Datapath for the window stack hit test block: stack cells, compare, raise.
// Depends on wsh_pkg; sequenced by the command word from wsh_ctrl.
`timescale 1ns / 1ps

module wsh_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  wsh_pkg::t_cmd                    i_cmd,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_rect_x_low,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_rect_y_low,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_rect_x_high,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_rect_y_high,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_click_x,
    input  logic [wsh_pkg::IN_COORD_W-1:0]   i_click_y,
    output wsh_pkg::t_dp_status              o_status,
    output logic                             o_strobe,
    output logic [wsh_pkg::STATUS_W-1:0]     o_result_status,
    output logic [wsh_pkg::ID_W-1:0]         o_window_id
);
    import wsh_pkg::*;

    // Stack cells, top of stack at position zero.
    t_cell                 r_cell [MAX_WINDOWS];
    t_cell                 n_cell [MAX_WINDOWS];
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    // Captured word.
    t_cell                 r_new;
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;

    logic [MAX_WINDOWS-1:0] r_hit;
    logic [MAX_WINDOWS-1:0] n_hit;

    logic [POS_W-1:0]      sel_pos;
    logic                  any_hit;
    t_cell                 sel_cell;

    logic                  r_strobe;
    logic [STATUS_W-1:0]   r_status;
    logic [ID_W-1:0]       r_id;

    // Every cell compares the captured point in parallel.
    always_comb begin
        for (int k = 0; k < MAX_WINDOWS; k++) begin
            n_hit[k] = (CNT_W'(k) < r_count)
                    && (r_cx >= r_cell[k].x_low) && (r_cx <= r_cell[k].x_high)
                    && (r_cy >= r_cell[k].y_low) && (r_cy <= r_cell[k].y_high);
        end
    end

    // The topmost hit wins.
    always_comb begin
        sel_pos = '0;
        any_hit = 1'b0;
        for (int k = MAX_WINDOWS - 1; k >= 0; k--) begin
            if (r_hit[k]) begin
                sel_pos = POS_W'(k);
                any_hit = 1'b1;
            end
        end
    end

    assign sel_cell = r_cell[sel_pos];

    always_comb begin
        for (int k = 0; k < MAX_WINDOWS; k++) begin
            n_cell[k] = r_cell[k];
        end
        n_count = r_count;
        if (i_cmd.do_load) begin
            for (int k = 1; k < MAX_WINDOWS; k++) begin
                n_cell[k] = r_cell[k-1];
            end
            n_cell[0]     = r_new;
            n_cell[0].idx = POS_W'(r_count);
            n_count       = r_count + CNT_W'(1);
        end else if (i_cmd.do_move && any_hit) begin
            // Cells above the hit slide down one place; the hit goes on top.
            for (int k = 1; k < MAX_WINDOWS; k++) begin
                if (POS_W'(k) <= sel_pos) begin
                    n_cell[k] = r_cell[k-1];
                end
            end
            n_cell[0] = sel_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_WINDOWS; k++) begin
            r_cell[k] <= n_cell[k];
        end
        if (i_cmd.capture) begin
            r_new.x_low  <= COORD_BITS'(i_rect_x_low);
            r_new.y_low  <= COORD_BITS'(i_rect_y_low);
            r_new.x_high <= COORD_BITS'(i_rect_x_high);
            r_new.y_high <= COORD_BITS'(i_rect_y_high);
            r_new.idx    <= '0;
            r_cx         <= COORD_BITS'(i_click_x);
            r_cy         <= COORD_BITS'(i_click_y);
        end
        if (i_cmd.do_cmp) begin
            r_hit <= n_hit;
        end
        if (i_cmd.emit_full) begin
            r_status <= ST_FULL;
            r_id     <= '0;
        end else if (i_cmd.do_move) begin
            r_status <= any_hit ? ST_HIT : ST_IGNORED;
            r_id     <= any_hit ? ID_W'({1'b0, sel_cell.idx} + (POS_W + 1)'(1)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.emit_full || i_cmd.do_move;
        end
    end

    assign o_status.full   = (r_count == CNT_W'(MAX_WINDOWS));
    assign o_strobe        = r_strobe;
    assign o_result_status = r_status;
    assign o_window_id     = r_id;

endmodule

@@ src/window_stack_hit_test_raise.sv @@
// Top level of the window stack with hit test and raise to front.
// Depends on wsh_pkg, wsh_ctrl and wsh_dp.
`timescale 1ns / 1ps

// Channel   Handshake              Word
// --------  ---------------------  -----------------------------------------
// request   start high, busy low   i_req_type, i_rect_*, i_click_x/y
// result    o_strobe, one cycle    o_status, o_window_id
//
// A load runs from acceptance through the capture, then the push onto the stack
// or the full-store report, before the next request is taken. A click runs
// through the capture, a parallel compare of the point against every stack cell,
// and a step that raises the topmost hit and registers the result. The strobe
// comes the cycle after that, with busy already low. Reset clears the window
// count and the controller, not the rectangles; the receiver cannot stall.

module window_stack_hit_test_raise (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_req_type,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_rect_x_low,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_rect_y_low,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_rect_x_high,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_rect_y_high,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_click_x,
    input  logic [wsh_pkg::IN_COORD_W-1:0] i_click_y,
    output logic                           o_strobe,
    output logic [wsh_pkg::STATUS_W-1:0]   o_status,
    output logic [wsh_pkg::ID_W-1:0]       o_window_id
);
    import wsh_pkg::*;

    t_cmd       cmd;
    t_dp_status dp_status;

    // The controller sequences one word at a time.
    wsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_status   (dp_status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // The datapath holds the stack cells in top-first order and the
    // registered result.
    wsh_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_rect_x_low    (i_rect_x_low),
        .i_rect_y_low    (i_rect_y_low),
        .i_rect_x_high   (i_rect_x_high),
        .i_rect_y_high   (i_rect_y_high),
        .i_click_x       (i_click_x),
        .i_click_y       (i_click_y),
        .o_status        (dp_status),
        .o_strobe        (o_strobe),
        .o_result_status (o_status),
        .o_window_id     (o_window_id)
    );

endmodule

@@ tb/window_stack_hit_test_raise_test.sv @@
// Self-checking testbench for window_stack_hit_test_raise: directed script, then random words.
// Depends on wsh_pkg and the window_stack_hit_test_raise RTL; reads no files.
`timescale 1ns / 1ps

module window_stack_hit_test_raise_test;

    import wsh_pkg::*;

    // This limit is far above the length of a run in which nothing is wrong.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_WORDS  = 410;
    localparam int SETTLE_CYCLES = 10;

    // One window rectangle with inclusive bounds.
    typedef struct packed {
        logic [COORD_BITS-1:0] x_low;
        logic [COORD_BITS-1:0] y_low;
        logic [COORD_BITS-1:0] x_high;
        logic [COORD_BITS-1:0] y_high;
    } t_pane;

    // What one result word carries.
    typedef struct packed {
        t_status_code     status;
        logic [ID_W-1:0]  window_id;
    } t_reply;

    // One row of the directed script. For a load, a..d are the rectangle; for a
    // click, a and b are the point. Rows marked fixed carry a result that is
    // obvious from the stack contents and is checked as written.
    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
        logic [COORD_BITS-1:0] c;
        logic [COORD_BITS-1:0] d;
        bit                    fixed;
        t_reply                reply;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic                  i_req_type;
    logic [IN_COORD_W-1:0] i_rect_x_low;
    logic [IN_COORD_W-1:0] i_rect_y_low;
    logic [IN_COORD_W-1:0] i_rect_x_high;
    logic [IN_COORD_W-1:0] i_rect_y_high;
    logic [IN_COORD_W-1:0] i_click_x;
    logic [IN_COORD_W-1:0] i_click_y;
    logic                  o_strobe;
    logic [STATUS_W-1:0]   o_status;
    logic [ID_W-1:0]       o_window_id;

    // Mirror of the block's state: rectangles in load order, the stacking
    // order as store indexes with the top first, and the number of windows.
    t_pane       stored_panes [MAX_WINDOWS];
    int          stack_slots  [MAX_WINDOWS];
    int          pane_count;

    t_reply      replies_due [$];
    t_script_row script [$];
    t_reply      arrived;
    int          fail_count;
    int          cycle_count;

    window_stack_hit_test_raise DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_rect_x_low  (i_rect_x_low),
        .i_rect_y_low  (i_rect_y_low),
        .i_rect_x_high (i_rect_x_high),
        .i_rect_y_high (i_rect_y_high),
        .i_click_x     (i_click_x),
        .i_click_y     (i_click_y),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_window_id   (o_window_id)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog. A hung handshake or a result that never comes ends up here.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Applies one accepted word to the mirrored stack and tells whether it
    // gives a result word, and which one. A load onto a full store is dropped
    // and reported as full. A click walks the stack from the top; the first
    // rectangle holding the point is raised to the top, and the others keep
    // their relative order. Inverted rectangles fail the bound test by
    // themselves, so they need no special handling.
    task automatic raise_hit_window(input logic kind, input t_pane pane,
                                    input logic [COORD_BITS-1:0] px,
                                    input logic [COORD_BITS-1:0] py,
                                    output bit gives_reply, output t_reply reply);
        int hit_pos;
        int slot;
        int k;
        t_pane p;
        gives_reply     = 1'b1;
        reply.status    = ST_IGNORED;
        reply.window_id = '0;
        if (kind == REQ_LOAD) begin
            if (pane_count >= MAX_WINDOWS) begin
                reply.status = ST_FULL;
            end else begin
                stored_panes[pane_count] = pane;
                for (k = pane_count; k > 0; k--) stack_slots[k] = stack_slots[k - 1];
                stack_slots[0] = pane_count;
                pane_count++;
                gives_reply = 1'b0;
            end
        end else begin
            hit_pos = -1;
            for (k = 0; k < pane_count; k++) begin
                p = stored_panes[stack_slots[k]];
                if (hit_pos < 0 && px >= p.x_low && px <= p.x_high
                        && py >= p.y_low && py <= p.y_high) begin
                    hit_pos = k;
                end
            end
            if (hit_pos >= 0) begin
                slot = stack_slots[hit_pos];
                for (k = hit_pos; k > 0; k--) stack_slots[k] = stack_slots[k - 1];
                stack_slots[0]  = slot;
                reply.status    = ST_HIT;
                reply.window_id = ID_W'(slot + 1);
            end
        end
    endtask

    // Presents one word at the falling edge and holds it until the block
    // takes it. The expected result is queued at the edge of acceptance.
    // Fields that the word's kind does not use still carry random bits.
    task automatic issue_word(input logic kind, input t_pane pane,
                              input logic [COORD_BITS-1:0] px,
                              input logic [COORD_BITS-1:0] py,
                              input bit fixed, input t_reply fixed_reply);
        bit     gives_reply;
        t_reply predicted;
        @(negedge i_clk);
        start         = 1'b1;
        i_req_type    = kind;
        i_rect_x_low  = pane.x_low;
        i_rect_y_low  = pane.y_low;
        i_rect_x_high = pane.x_high;
        i_rect_y_high = pane.y_high;
        i_click_x     = px;
        i_click_y     = py;
        do @(posedge i_clk); while (busy !== 1'b0);
        raise_hit_window(kind, pane, px, py, gives_reply, predicted);
        if (gives_reply) replies_due.push_back(fixed ? fixed_reply : predicted);
    endtask

    // Leaves start low for a number of whole cycles.
    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected result word has arrived.
    task automatic drain_replies;
        @(negedge i_clk);
        start = 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_script_row script_row(input logic kind,
                                               input int a, input int b,
                                               input int c, input int d,
                                               input bit fixed,
                                               input t_status_code status,
                                               input int window_id);
        t_script_row row;
        row.kind            = kind;
        row.a               = COORD_BITS'(a);
        row.b               = COORD_BITS'(b);
        row.c               = COORD_BITS'(c);
        row.d               = COORD_BITS'(d);
        row.fixed           = fixed;
        row.reply.status    = status;
        row.reply.window_id = ID_W'(window_id);
        return row;
    endfunction

    // Builds a random word. Most clicks aim at a stored rectangle, at its
    // corners or just past its right edge, so that hits and raises dominate.
    // Loads mix ordinary, inverted, single point and fully random rectangles.
    // Once the store holds its last window every load is a full-store case.
    task automatic random_word(output logic kind, output t_pane pane,
                               output logic [COORD_BITS-1:0] px,
                               output logic [COORD_BITS-1:0] py);
        t_pane target;
        int    shape;
        pane = t_pane'({$urandom, $urandom});
        px   = COORD_BITS'($urandom);
        py   = COORD_BITS'($urandom);
        if ($urandom_range(0, 99) < 25) begin
            kind  = REQ_LOAD;
            shape = $urandom_range(0, 9);
            if (shape == 0) begin
                pane.x_low  = COORD_BITS'($urandom_range(1, 4095));
                pane.x_high = COORD_BITS'($urandom_range(0, pane.x_low - 1));
            end else if (shape == 1) begin
                pane.y_low  = COORD_BITS'($urandom_range(1, 4095));
                pane.y_high = COORD_BITS'($urandom_range(0, pane.y_low - 1));
            end else if (shape == 2) begin
                pane.x_high = pane.x_low;
                pane.y_high = pane.y_low;
            end else if (shape > 3) begin
                pane.x_low  = COORD_BITS'($urandom_range(0, 4095));
                pane.x_high = COORD_BITS'($urandom_range(pane.x_low, 4095));
                pane.y_low  = COORD_BITS'($urandom_range(0, 4095));
                pane.y_high = COORD_BITS'($urandom_range(pane.y_low, 4095));
            end
        end else begin
            kind = REQ_CLICK;
            if (pane_count > 0 && $urandom_range(0, 99) < 80) begin
                target = stored_panes[$urandom_range(0, pane_count - 1)];
                shape  = $urandom_range(0, 5);
                if (shape == 0) begin
                    px = target.x_low;
                    py = target.y_low;
                end else if (shape == 1) begin
                    px = target.x_high;
                    py = target.y_high;
                end else if (shape == 2) begin
                    px = target.x_high + 1'b1;
                    py = COORD_BITS'($urandom_range(target.y_low, target.y_high));
                end else begin
                    // For an inverted rectangle this lands between its edges,
                    // where it must still not count as a hit.
                    px = COORD_BITS'($urandom_range(target.x_low, target.x_high));
                    py = COORD_BITS'($urandom_range(target.y_low, target.y_high));
                end
            end
        end
    endtask

    // Result checker. The receiver cannot stall, so every strobe is a word
    // that must match the oldest expectation field by field.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (replies_due.size() == 0) begin
                $error("result word with none expected: o_status %0d, o_window_id %0d",
                       o_status, o_window_id);
                fail_count++;
            end else begin
                arrived = replies_due.pop_front();
                if (o_status !== arrived.status) begin
                    $error("o_status: expected %0d, got %0d", arrived.status, o_status);
                    fail_count++;
                end
                if (o_window_id !== arrived.window_id) begin
                    $error("o_window_id: expected %0d, got %0d",
                           arrived.window_id, o_window_id);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        int                    i;
        int                    phase;
        int                    idle_pct [4];
        logic                  kind;
        t_pane                 pane;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        t_script_row           row;
        t_reply                none_typed;

        fail_count    = 0;
        pane_count    = 0;
        none_typed    = '0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_req_type    = REQ_LOAD;
        i_rect_x_low  = '0;
        i_rect_y_low  = '0;
        i_rect_x_high = '0;
        i_rect_y_high = '0;
        i_click_x     = '0;
        i_click_y     = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed script. It starts on the empty stack, then builds a stack
        // of a full-screen window, an inverted one, a small one, a single point,
        // another inverted one and one more, probing inclusive corners, near misses and raises.
        script.push_back(script_row(REQ_CLICK, 0, 0, 0, 0, 1, ST_IGNORED, 0));
        script.push_back(script_row(REQ_CLICK, 4095, 4095, 0, 0, 1, ST_IGNORED, 0));
        script.push_back(script_row(REQ_LOAD, 0, 0, 4095, 4095, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 0, 0, 0, 0, 1, ST_HIT, 1));
        script.push_back(script_row(REQ_CLICK, 4095, 4095, 0, 0, 1, ST_HIT, 1));
        script.push_back(script_row(REQ_CLICK, 4095, 0, 0, 0, 1, ST_HIT, 1));
        script.push_back(script_row(REQ_LOAD, 100, 0, 50, 4095, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 75, 10, 0, 0, 1, ST_HIT, 1));
        script.push_back(script_row(REQ_LOAD, 10, 20, 30, 40, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 10, 20, 0, 0, 1, ST_HIT, 3));
        script.push_back(script_row(REQ_CLICK, 30, 40, 0, 0, 1, ST_HIT, 3));
        script.push_back(script_row(REQ_CLICK, 31, 40, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 20, 30, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 9, 20, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_LOAD, 4095, 4095, 4095, 4095, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 4095, 4095, 0, 0, 1, ST_HIT, 4));
        script.push_back(script_row(REQ_LOAD, 2048, 2048, 2047, 2047, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 2048, 2047, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_LOAD, 'hAAA, 'h555, 'hFFF, 'hFFF, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 'hAAA, 'h555, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 'h555, 'hAAA, 0, 0, 0, ST_HIT, 0));
        script.push_back(script_row(REQ_CLICK, 20, 30, 0, 0, 0, ST_HIT, 0));

        for (i = 0; i < script.size(); i++) begin
            row = script[i];
            if (row.kind == REQ_LOAD) begin
                pane = '{row.a, row.b, row.c, row.d};
                px   = COORD_BITS'($urandom);
                py   = COORD_BITS'($urandom);
            end else begin
                pane = t_pane'({$urandom, $urandom});
                px   = row.a;
                py   = row.b;
            end
            issue_word(row.kind, pane, px, py, row.fixed, row.reply);
        end

        // Random phases. The sender idles at random in some of them; the
        // receiver has no way to stall, so phases that would stall it run
        // with the sender's idling alone. Each phase ends with a full drain,
        // which also puts pauses with nothing outstanding into the run.
        idle_pct = '{0, 63, 0, 22};
        for (phase = 0; phase < 4; phase++) begin
            drain_replies();
            for (i = 0; i < RANDOM_WORDS; i++) begin
                if (idle_pct[phase] > 0 && $urandom_range(0, 99) < idle_pct[phase])
                    hold_off($urandom_range(1, 4));
                random_word(kind, pane, px, py);
                issue_word(kind, pane, px, py, 1'b0, none_typed);
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/wsh_pkg.sv
src/wsh_ctrl.sv
src/wsh_dp.sv
src/window_stack_hit_test_raise.sv
tb/window_stack_hit_test_raise_test.sv
